// ----- hdl/otg_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Overlapping tile grid package
// Shared widths, register indexes, controller states, command and status
// structures, and the origin clamp used by the tile grid datapath.
// ----------------------------------------------------------------------------
package otg_pkg;

	// Fixed field widths.
	localparam int DIM_W           = 14;
	localparam int RATIO_W         = 17;
	localparam int RATIO_FRAC_BITS = 16;
	localparam int CNT_W           = 16;
	localparam int IDX_W           = 6;
	localparam int LIM_W           = 7;
	localparam int MAX_TILES       = 64;

	// Derived arithmetic widths.
	localparam int NUM_W  = DIM_W + RATIO_FRAC_BITS;
	localparam int DEN_W  = DIM_W + RATIO_W;
	localparam int QSUM_W = NUM_W + 1;
	localparam int ACC_W  = IDX_W + DIM_W;
	localparam int TOT_W  = 2 * CNT_W;
	localparam int CFG_W  = RATIO_W;
	localparam int ADDR_W = 3;

	localparam logic [RATIO_W-1:0] ONE_RATIO = RATIO_W'(1 << RATIO_FRAC_BITS);
	localparam logic [CNT_W-1:0]   CNT_SAT   = {CNT_W{1'b1}};

	// Payload widths, padded to whole bytes.
	localparam int IN_DATA_W  = 32;
	localparam int OUT_DATA_W = 72;

	// Configuration register indexes.
	localparam logic [ADDR_W-1:0] CFG_TILE_WIDTH  = 3'd0;
	localparam logic [ADDR_W-1:0] CFG_TILE_HEIGHT = 3'd1;
	localparam logic [ADDR_W-1:0] CFG_RATIO_X     = 3'd2;
	localparam logic [ADDR_W-1:0] CFG_RATIO_Y     = 3'd3;
	localparam logic [ADDR_W-1:0] CFG_TILE_LIMIT  = 3'd4;

	// Configuration reset values.
	localparam logic [DIM_W-1:0]   RST_TILE_DIM   = DIM_W'(640);
	localparam logic [RATIO_W-1:0] RST_RATIO      = RATIO_W'(13107);
	localparam logic [LIM_W-1:0]   RST_TILE_LIMIT = LIM_W'(64);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_START,
		ST_DIV,
		ST_COUNT,
		ST_TOTAL,
		ST_EMIT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic prep;
		logic div_start;
		logic count;
		logic init;
		logic step;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic div_done;
		logic last;
	} status_t;

	// Clamp an accumulated origin against the far edge dim - tile.
	function automatic logic [DIM_W-1:0] clamp_origin(
		input logic [ACC_W-1:0]        acc,
		input logic signed [DIM_W:0]   hi
	);
		logic [DIM_W-1:0] res;
		if (hi < 0) begin
			res = hi[DIM_W-1:0];
		end else if (acc > ACC_W'(hi[DIM_W-1:0])) begin
			res = hi[DIM_W-1:0];
		end else begin
			res = acc[DIM_W-1:0];
		end
		return res;
	endfunction

endpackage

// ----- hdl/overlapping_tile_grid_generator_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Overlapping tile grid generator
// Turns one image size request into a column-major list of overlapping
// tile origins, using the configured tile size, overlap and tile limit.
// ----------------------------------------------------------------------------
// Usage:
// A request arrives on the s_ channel with the image width and height. The
// block answers with one m_ transaction per tile: index, clamped origin,
// tile counts per axis, and a flag in m_tuser when the list was cut at the
// tile limit. m_tlast marks the final tile of the image.
// The first tile is offered once the controller has passed its capture,
// setup, start, division, count and total states; two 30-step restoring
// dividers, one per axis, run in parallel during division. Further tiles
// follow one per cycle while m_tready is high. One request is in flight
// at a time: s_tready is high only while idle. A stalled receiver simply
// holds the current tile; nothing is dropped. Configuration is written
// through cfg_we/cfg_addr/cfg_wdata only while idle; the user must keep to
// this; the block does not enforce it. Reset restores the defaults (640 x
// 640 tiles, overlap 13107/65536, limit 64) and returns the block to idle.
// ----------------------------------------------------------------------------
module overlapping_tile_grid_generator_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [otg_pkg::ADDR_W-1:0]         cfg_addr,
	input  logic [otg_pkg::CFG_W-1:0]          cfg_wdata,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// image_width[13:0], image_height[27:14], zero pad to 32 bits
	input  logic [otg_pkg::IN_DATA_W-1:0]      s_tdata,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// tile_index[5:0], origin_x[19:6], origin_y[33:20],
	// tiles_across[49:34], tiles_down[65:50], zero pad to 72 bits
	output logic [otg_pkg::OUT_DATA_W-1:0]     m_tdata,
	// over_limit[0]
	output logic                               m_tuser,
	output logic                               m_tlast
);
	import otg_pkg::*;

	cmd_t    cmd;
	status_t status;

	logic [IDX_W-1:0] tile_index;
	logic [DIM_W-1:0] origin_x;
	logic [DIM_W-1:0] origin_y;
	logic [CNT_W-1:0] tiles_across;
	logic [CNT_W-1:0] tiles_down;
	logic             over_limit;

	otg_controller u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	otg_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_addr     (cfg_addr),
		.cfg_wdata    (cfg_wdata),
		.image_width  (s_tdata[DIM_W-1:0]),
		.image_height (s_tdata[2*DIM_W-1:DIM_W]),
		.cmd          (cmd),
		.status       (status),
		.tile_index   (tile_index),
		.origin_x     (origin_x),
		.origin_y     (origin_y),
		.tiles_across (tiles_across),
		.tiles_down   (tiles_down),
		.over_limit   (over_limit)
	);

	// Pack the tile descriptor.
	assign m_tdata = {6'b0, tiles_down, tiles_across, origin_y, origin_x, tile_index};
	assign m_tuser = over_limit;
	assign m_tlast = status.last;

	// The block never offers a tile while it can take a request.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("request and tile offered at once");

	// Tiles of one image are offered back to back.
	a_tiles_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
		else $error("gap between tiles of one image");

	// Tile indexes count up by one.
	a_index_step: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && !m_tlast) |=>
		(m_tdata[IDX_W-1:0] == IDX_W'($past(m_tdata[IDX_W-1:0]) + 1'b1)))
		else $error("tile index did not advance by one");

	// After the final tile the block is ready for the next request.
	a_idle_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast) |=> s_tready)
		else $error("not idle after final tile");

	// A new request is never answered in the following cycle.
	a_no_early_tile: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !m_tvalid)
		else $error("tile offered too early");

endmodule

// ----- hdl/otg_divider.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Iterative unsigned divider
// Restoring division, one quotient bit per cycle.
// Gives the quotient and a flag telling whether the remainder is nonzero.
// ----------------------------------------------------------------------------
module otg_divider (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [otg_pkg::NUM_W-1:0]  num,
	input  logic [otg_pkg::DEN_W-1:0]  den,
	output logic [otg_pkg::NUM_W-1:0]  quotient,
	output logic                       rem_nz,
	output logic                       done
);
	import otg_pkg::*;

	localparam int CNT_BITS = $clog2(NUM_W + 1);

	logic [DEN_W-1:0]    rem_q;
	logic [NUM_W-1:0]    quo_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic                busy_q;
	logic                done_q;

	logic [DEN_W:0]      shifted;
	logic                fits;

	// Trial subtraction of the divisor from the shifted partial remainder.
	always_comb begin
		shifted = {rem_q, quo_q[NUM_W-1]};
		fits    = shifted >= {1'b0, den};
	end

	// Control: step counter, busy and done flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNT_BITS'(NUM_W);
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_BITS'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// Datapath: partial remainder and quotient shift register.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= DEN_W'(shifted - {1'b0, den});
			end else begin
				rem_q <= shifted[DEN_W-1:0];
			end
			quo_q <= {quo_q[NUM_W-2:0], fits};
		end
	end

	assign quotient = quo_q;
	assign rem_nz   = |rem_q;
	assign done     = done_q;

endmodule

// ----- hdl/otg_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tile grid datapath
// Holds the configuration registers, computes per-axis tile counts and
// strides, and walks the tile grid in column-major order under controller
// command, producing one tile descriptor per step.
// ----------------------------------------------------------------------------
module otg_datapath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [otg_pkg::ADDR_W-1:0]       cfg_addr,
	input  logic [otg_pkg::CFG_W-1:0]        cfg_wdata,
	input  logic [otg_pkg::DIM_W-1:0]        image_width,
	input  logic [otg_pkg::DIM_W-1:0]        image_height,
	input  otg_pkg::cmd_t                    cmd,
	output otg_pkg::status_t                 status,
	output logic [otg_pkg::IDX_W-1:0]        tile_index,
	output logic [otg_pkg::DIM_W-1:0]        origin_x,
	output logic [otg_pkg::DIM_W-1:0]        origin_y,
	output logic [otg_pkg::CNT_W-1:0]        tiles_across,
	output logic [otg_pkg::CNT_W-1:0]        tiles_down,
	output logic                             over_limit
);
	import otg_pkg::*;

	// Configuration registers.
	logic [DIM_W-1:0]   tile_w_q;
	logic [DIM_W-1:0]   tile_h_q;
	logic [RATIO_W-1:0] ratio_x_q;
	logic [RATIO_W-1:0] ratio_y_q;
	logic [LIM_W-1:0]   limit_q;

	// Per-image registers.
	logic [DIM_W-1:0]        img_w_q;
	logic [DIM_W-1:0]        img_h_q;
	logic                    one_x_q;
	logic                    one_y_q;
	logic [NUM_W-1:0]        num_x_q;
	logic [NUM_W-1:0]        num_y_q;
	logic [DEN_W-1:0]        den_x_q;
	logic [DEN_W-1:0]        den_y_q;
	logic [DEN_W-1:0]        ovp_x_q;
	logic [DEN_W-1:0]        ovp_y_q;
	logic signed [DIM_W:0]   hi_x_q;
	logic signed [DIM_W:0]   hi_y_q;
	logic [CNT_W-1:0]        ca_q;
	logic [CNT_W-1:0]        cd_q;
	logic [DIM_W-1:0]        stride_x_q;
	logic [DIM_W-1:0]        stride_y_q;
	logic [LIM_W-1:0]        emit_q;
	logic                    over_q;

	// Grid walk registers.
	logic [IDX_W-1:0] k_q;
	logic [IDX_W-1:0] row_q;
	logic [ACC_W-1:0] acc_x_q;
	logic [ACC_W-1:0] acc_y_q;
	logic [DIM_W-1:0] org_x_q;
	logic [DIM_W-1:0] org_y_q;

	// Divider connections.
	logic [NUM_W-1:0] quo_x, quo_y;
	logic             rnz_x, rnz_y;
	logic             done_x, done_y;

	// Combinational helpers.
	logic                one_x, one_y;
	logic [RATIO_W-1:0]  inv_x, inv_y;
	logic [QSUM_W-1:0]   qsum_x, qsum_y;
	logic [CNT_W-1:0]    cnt_x, cnt_y;
	logic [DIM_W:0]      ov_x, ov_y;
	logic [DIM_W-1:0]    str_x, str_y;
	logic [TOT_W-1:0]    total;
	logic [LIM_W-1:0]    lim;
	logic                over;
	logic                last;
	logic                wrap;
	logic [ACC_W-1:0]    nxt_acc_x, nxt_acc_y;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tile_w_q  <= RST_TILE_DIM;
			tile_h_q  <= RST_TILE_DIM;
			ratio_x_q <= RST_RATIO;
			ratio_y_q <= RST_RATIO;
			limit_q   <= RST_TILE_LIMIT;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_TILE_WIDTH:  tile_w_q  <= cfg_wdata[DIM_W-1:0];
				CFG_TILE_HEIGHT: tile_h_q  <= cfg_wdata[DIM_W-1:0];
				CFG_RATIO_X:     ratio_x_q <= cfg_wdata[RATIO_W-1:0];
				CFG_RATIO_Y:     ratio_y_q <= cfg_wdata[RATIO_W-1:0];
				CFG_TILE_LIMIT:  limit_q   <= cfg_wdata[LIM_W-1:0];
				default: ;
			endcase
		end
	end

	// Setup terms: degenerate axis flags and the step denominators.
	always_comb begin
		one_x = (ratio_x_q >= ONE_RATIO) || (tile_w_q == '0) || (img_w_q <= tile_w_q);
		one_y = (ratio_y_q >= ONE_RATIO) || (tile_h_q == '0) || (img_h_q <= tile_h_q);
		inv_x = ONE_RATIO - ratio_x_q;
		inv_y = ONE_RATIO - ratio_y_q;
	end

	// Count and stride per axis from the divider results.
	always_comb begin
		qsum_x = {1'b0, quo_x} + QSUM_W'(rnz_x) + QSUM_W'(1);
		qsum_y = {1'b0, quo_y} + QSUM_W'(rnz_y) + QSUM_W'(1);
		if (one_x_q) begin
			cnt_x = CNT_W'(1);
		end else if (qsum_x > QSUM_W'(CNT_SAT)) begin
			cnt_x = CNT_SAT;
		end else begin
			cnt_x = qsum_x[CNT_W-1:0];
		end
		if (one_y_q) begin
			cnt_y = CNT_W'(1);
		end else if (qsum_y > QSUM_W'(CNT_SAT)) begin
			cnt_y = CNT_SAT;
		end else begin
			cnt_y = qsum_y[CNT_W-1:0];
		end
		ov_x  = ovp_x_q[RATIO_FRAC_BITS +: DIM_W+1];
		ov_y  = ovp_y_q[RATIO_FRAC_BITS +: DIM_W+1];
		str_x = (ov_x >= {1'b0, tile_w_q}) ? '0 : DIM_W'(tile_w_q - ov_x[DIM_W-1:0]);
		str_y = (ov_y >= {1'b0, tile_h_q}) ? '0 : DIM_W'(tile_h_q - ov_y[DIM_W-1:0]);
	end

	// Tile total against the limit.
	always_comb begin
		total = ca_q * cd_q;
		if (limit_q == '0) begin
			lim = LIM_W'(1);
		end else if (limit_q > LIM_W'(MAX_TILES)) begin
			lim = LIM_W'(MAX_TILES);
		end else begin
			lim = limit_q;
		end
		over = total > TOT_W'(lim);
	end

	// Next grid position.
	always_comb begin
		last = (LIM_W'(k_q) + LIM_W'(1)) == emit_q;
		wrap = (CNT_W'(row_q) + CNT_W'(1)) >= cd_q;
		if (wrap) begin
			nxt_acc_x = acc_x_q + ACC_W'(stride_x_q);
			nxt_acc_y = '0;
		end else begin
			nxt_acc_x = acc_x_q;
			nxt_acc_y = acc_y_q + ACC_W'(stride_y_q);
		end
	end

	// Per-image computation sequence.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			img_w_q <= image_width;
			img_h_q <= image_height;
		end
		if (cmd.prep) begin
			one_x_q <= one_x;
			one_y_q <= one_y;
			num_x_q <= one_x ? '0 : NUM_W'(img_w_q - tile_w_q) << RATIO_FRAC_BITS;
			num_y_q <= one_y ? '0 : NUM_W'(img_h_q - tile_h_q) << RATIO_FRAC_BITS;
			den_x_q <= {{RATIO_W{1'b0}}, tile_w_q} * {{DIM_W{1'b0}}, inv_x};
			den_y_q <= {{RATIO_W{1'b0}}, tile_h_q} * {{DIM_W{1'b0}}, inv_y};
			ovp_x_q <= {{RATIO_W{1'b0}}, tile_w_q} * {{DIM_W{1'b0}}, ratio_x_q};
			ovp_y_q <= {{RATIO_W{1'b0}}, tile_h_q} * {{DIM_W{1'b0}}, ratio_y_q};
			hi_x_q  <= $signed({1'b0, img_w_q}) - $signed({1'b0, tile_w_q});
			hi_y_q  <= $signed({1'b0, img_h_q}) - $signed({1'b0, tile_h_q});
		end
		if (cmd.count) begin
			ca_q       <= cnt_x;
			cd_q       <= cnt_y;
			stride_x_q <= str_x;
			stride_y_q <= str_y;
		end
		if (cmd.init) begin
			over_q  <= over;
			emit_q  <= over ? lim : total[LIM_W-1:0];
			k_q     <= '0;
			row_q   <= '0;
			acc_x_q <= '0;
			acc_y_q <= '0;
			org_x_q <= clamp_origin('0, hi_x_q);
			org_y_q <= clamp_origin('0, hi_y_q);
		end else if (cmd.step) begin
			k_q     <= k_q + 1'b1;
			row_q   <= wrap ? '0 : row_q + 1'b1;
			acc_x_q <= nxt_acc_x;
			acc_y_q <= nxt_acc_y;
			org_x_q <= clamp_origin(nxt_acc_x, hi_x_q);
			org_y_q <= clamp_origin(nxt_acc_y, hi_y_q);
		end
	end

	// Two dividers run side by side, one per axis.
	otg_divider u_div_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.num      (num_x_q),
		.den      (den_x_q),
		.quotient (quo_x),
		.rem_nz   (rnz_x),
		.done     (done_x)
	);

	otg_divider u_div_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.num      (num_y_q),
		.den      (den_y_q),
		.quotient (quo_y),
		.rem_nz   (rnz_y),
		.done     (done_y)
	);

	assign status.div_done = done_x & done_y;
	assign status.last     = last;

	assign tile_index   = k_q;
	assign origin_x     = org_x_q;
	assign origin_y     = org_y_q;
	assign tiles_across = ca_q;
	assign tiles_down   = cd_q;
	assign over_limit   = over_q;

endmodule

// ----- hdl/otg_controller.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tile grid controller
// Sequences one image request: capture, setup products, division, count
// and stride, total against the limit, then tile emission.
// ----------------------------------------------------------------------------
module otg_controller (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	output logic              m_tvalid,
	input  logic              m_tready,
	input  otg_pkg::status_t  status,
	output otg_pkg::cmd_t     cmd
);
	import otg_pkg::*;

	state_t state_q;
	state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		m_tvalid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					state_d     = ST_PREP;
				end
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				state_d  = ST_START;
			end
			ST_START: begin
				cmd.div_start = 1'b1;
				state_d       = ST_DIV;
			end
			ST_DIV: begin
				if (status.div_done) begin
					state_d = ST_COUNT;
				end
			end
			ST_COUNT: begin
				cmd.count = 1'b1;
				state_d   = ST_TOTAL;
			end
			ST_TOTAL: begin
				cmd.init = 1'b1;
				state_d  = ST_EMIT;
			end
			ST_EMIT: begin
				m_tvalid = 1'b1;
				if (m_tready) begin
					if (status.last) begin
						state_d = ST_IDLE;
					end else begin
						cmd.step = 1'b1;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ----- tb/sv/otg_tile_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tile grid checker
// Watches the configuration port and both stream channels of the tile grid
// generator. It keeps its own copy of the registers, works out the full tile
// list for every accepted image request, and compares each tile transaction
// with the oldest tile still owed.
// ----------------------------------------------------------------------------
module otg_tile_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [otg_pkg::ADDR_W-1:0]     cfg_addr,
	input  logic [otg_pkg::CFG_W-1:0]      cfg_wdata,
	input  logic                           s_tvalid,
	input  logic                           s_tready,
	input  logic [otg_pkg::IN_DATA_W-1:0]  s_tdata,
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	input  logic [otg_pkg::OUT_DATA_W-1:0] m_tdata,
	input  logic                           m_tuser,
	input  logic                           m_tlast,
	output int                             tile_errors,
	output int                             tiles_pending,
	output int                             tiles_checked
);
	import otg_pkg::*;

	// One tile as it appears on the output, index in the lowest bits.
	typedef struct packed {
		logic             last;
		logic             over;
		logic [CNT_W-1:0] down;
		logic [CNT_W-1:0] across;
		logic [DIM_W-1:0] origin_y;
		logic [DIM_W-1:0] origin_x;
		logic [IDX_W-1:0] index;
	} tile_t;

	localparam longint unsigned UNIT_RATIO = 64'd1 << RATIO_FRAC_BITS;

	// Shadow copy of the configuration registers.
	logic [DIM_W-1:0]   tile_w  = RST_TILE_DIM;
	logic [DIM_W-1:0]   tile_h  = RST_TILE_DIM;
	logic [RATIO_W-1:0] ratio_x = RST_RATIO;
	logic [RATIO_W-1:0] ratio_y = RST_RATIO;
	logic [LIM_W-1:0]   tile_lim = RST_TILE_LIMIT;

	tile_t pending_tiles[$];
	tile_t expected_tile;
	tile_t actual_tile;

	initial begin
		tile_errors   = 0;
		tiles_pending = 0;
		tiles_checked = 0;
	end

	// Tiles needed along one axis: ceil((dim - tile) / step) + 1, saturating.
	function automatic longint unsigned tiles_on_axis(longint unsigned dim,
			longint unsigned tile, longint unsigned ratio);
		longint unsigned num;
		longint unsigned den;
		longint unsigned q;
		q = 1;
		if (ratio < UNIT_RATIO && tile != 0 && dim > tile) begin
			num = (dim - tile) << RATIO_FRAC_BITS;
			den = tile * (UNIT_RATIO - ratio);
			q = (num + den - 1) / den + 1;
			if (q > 65535)
				q = 65535;
		end
		return q;
	endfunction

	// Step between neighboring tiles; zero once the overlap covers the tile.
	function automatic longint unsigned step_on_axis(longint unsigned tile,
			longint unsigned ratio);
		longint unsigned ov;
		ov = (tile * ratio) >> RATIO_FRAC_BITS;
		return (ov >= tile) ? 0 : tile - ov;
	endfunction

	// Origin pulled back so the tile ends at the far edge, kept to 14 bits.
	function automatic logic [DIM_W-1:0] tile_origin(longint unsigned dim,
			longint unsigned tile, longint unsigned pos, longint unsigned step);
		longint hi;
		longint v;
		hi = longint'(dim) - longint'(tile);
		v = longint'(pos * step);
		if (v > hi)
			v = hi;
		return DIM_W'(v);
	endfunction

	// Queue every tile that one image request must produce.
	task automatic predict_tile_grid(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
		longint unsigned across;
		longint unsigned down;
		longint unsigned sx;
		longint unsigned sy;
		longint unsigned lim;
		longint unsigned emit;
		longint unsigned col;
		longint unsigned row;
		logic over;
		tile_t t;
		across = tiles_on_axis(w, tile_w, ratio_x);
		down   = tiles_on_axis(h, tile_h, ratio_y);
		sx     = step_on_axis(tile_w, ratio_x);
		sy     = step_on_axis(tile_h, ratio_y);
		lim    = tile_lim;
		if (lim == 0)
			lim = 1;
		if (lim > MAX_TILES)
			lim = MAX_TILES;
		over = (across * down > lim);
		emit = over ? lim : across * down;
		col = 0;
		row = 0;
		for (longint unsigned k = 0; k < emit; k++) begin
			t.index    = IDX_W'(k);
			t.origin_x = tile_origin(w, tile_w, col, sx);
			t.origin_y = tile_origin(h, tile_h, row, sy);
			t.across   = CNT_W'(across);
			t.down     = CNT_W'(down);
			t.over     = over;
			t.last     = (k + 1 == emit);
			pending_tiles.push_back(t);
			// Column-major walk: all rows of a column before the next column.
			row++;
			if (row >= down) begin
				row = 0;
				col++;
			end
		end
	endtask

	// Track register writes, predict on requests, compare on tiles.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tile_w   = RST_TILE_DIM;
			tile_h   = RST_TILE_DIM;
			ratio_x  = RST_RATIO;
			ratio_y  = RST_RATIO;
			tile_lim = RST_TILE_LIMIT;
			pending_tiles.delete();
			tiles_pending = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					CFG_TILE_WIDTH:  tile_w   = cfg_wdata[DIM_W-1:0];
					CFG_TILE_HEIGHT: tile_h   = cfg_wdata[DIM_W-1:0];
					CFG_RATIO_X:     ratio_x  = cfg_wdata[RATIO_W-1:0];
					CFG_RATIO_Y:     ratio_y  = cfg_wdata[RATIO_W-1:0];
					CFG_TILE_LIMIT:  tile_lim = cfg_wdata[LIM_W-1:0];
					default: ;
				endcase
			end

			if (s_tvalid && s_tready)
				predict_tile_grid(s_tdata[DIM_W-1:0], s_tdata[2*DIM_W-1:DIM_W]);

			if (m_tvalid && m_tready) begin
				actual_tile = tile_t'({m_tlast, m_tuser, m_tdata[$bits(tile_t)-3:0]});
				if (pending_tiles.size() == 0) begin
					tile_errors++;
					if (tile_errors <= 10)
						$display("Unexpected tile transaction: index %0d origin (%0d, %0d)",
							actual_tile.index, $signed(actual_tile.origin_x),
							$signed(actual_tile.origin_y));
				end else begin
					expected_tile = pending_tiles.pop_front();
					if (actual_tile !== expected_tile) begin
						tile_errors++;
						if (tile_errors <= 10) begin
							$display("Tile %0d mismatch: expected idx %0d x %0d y %0d across %0d down %0d over %b last %b",
								tiles_checked, expected_tile.index,
								$signed(expected_tile.origin_x),
								$signed(expected_tile.origin_y), expected_tile.across,
								expected_tile.down, expected_tile.over, expected_tile.last);
							$display("        got idx %0d x %0d y %0d across %0d down %0d over %b last %b",
								actual_tile.index, $signed(actual_tile.origin_x),
								$signed(actual_tile.origin_y), actual_tile.across,
								actual_tile.down, actual_tile.over, actual_tile.last);
						end
					end
				end
				tiles_checked++;
			end

			tiles_pending = pending_tiles.size();
		end
	end

endmodule

// ----- tb/sv/tb_overlapping_tile_grid_generator_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tile grid generator testbench
// Drives image size requests and register settings into the tile grid
// generator, with random gaps on the request side and random back-pressure
// on the tile side. A directed set covers edge sizes, overlaps and limits,
// then random phases each run under a fresh setting. The checker beside the
// block predicts and compares every tile.
// ----------------------------------------------------------------------------
module tb_overlapping_tile_grid_generator_core;
	import otg_pkg::*;

	localparam int WATCHDOG_LIMIT   = 2000;
	localparam int SETTLE_CYCLES    = 4;
	localparam int TAIL_CYCLES      = 40;
	localparam int RANDOM_PHASES    = 7;
	localparam int IMAGES_PER_PHASE = 44;

	// An index past the register map; writes to it must be ignored.
	localparam logic [ADDR_W-1:0] CFG_SPARE = 3'd7;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [ADDR_W-1:0]     cfg_addr  = '0;
	logic [CFG_W-1:0]      cfg_wdata = '0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	// image_width[13:0], image_height[27:14], zero pad to 32 bits
	logic [IN_DATA_W-1:0]  s_tdata   = '0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	// tile_index[5:0], origin_x[19:6], origin_y[33:20],
	// tiles_across[49:34], tiles_down[65:50], zero pad to 72 bits
	logic [OUT_DATA_W-1:0] m_tdata;
	// over_limit[0]
	logic                  m_tuser;
	logic                  m_tlast;

	int tile_errors;
	int tiles_pending;
	int tiles_checked;
	int images_sent   = 0;
	int settings_used = 1;
	int ready_hold    = 0;
	int idle_cycles   = 0;
	bit quiet         = 1'b0;

	overlapping_tile_grid_generator_core i_dut (.*);

	otg_tile_checker i_checker (.*);

	always #2 clk = ~clk;

	// Tile side back-pressure in random bursts.
	always @(negedge clk) begin
		if (quiet) begin
			m_tready <= 1'b1;
		end else if (ready_hold > 0) begin
			m_tready   <= 1'b0;
			ready_hold <= ready_hold - 1;
		end else if ($urandom_range(0, 4) == 0) begin
			m_tready   <= 1'b0;
			ready_hold <= $urandom_range(0, 3);
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Watchdog on cycles with no transaction on either channel.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [CFG_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_addr  <= addr;
		cfg_wdata <= value;
		@(negedge clk);
	endtask

	task automatic set_config(input int tw, input int th, input int rx, input int ry,
			input int lim);
		write_reg(CFG_TILE_WIDTH, CFG_W'(tw));
		write_reg(CFG_TILE_HEIGHT, CFG_W'(th));
		write_reg(CFG_RATIO_X, CFG_W'(rx));
		write_reg(CFG_RATIO_Y, CFG_W'(ry));
		write_reg(CFG_TILE_LIMIT, CFG_W'(lim));
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	task automatic wait_drained();
		while (tiles_pending != 0)
			@(negedge clk);
	endtask

	// Stop requests, let every owed tile arrive, then let the block go idle.
	task automatic end_phase();
		s_tvalid <= 1'b0;
		wait_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Offer one image request; called and returns at a falling edge.
	task automatic send_image(input int w, input int h);
		if (!quiet && $urandom_range(0, 15) == 0) begin
			s_tvalid <= 1'b0;
			wait_drained();
			@(negedge clk);
		end else if (!quiet && $urandom_range(0, 2) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= IN_DATA_W'({DIM_W'(h), DIM_W'(w)});
		do
			@(posedge clk);
		while (!s_tready);
		@(negedge clk);
		images_sent++;
	endtask

	function automatic int pick_tile();
		case ($urandom_range(0, 9))
			0:       return $urandom_range(0, 16383);
			1:       return $urandom_range(0, 15);
			default: return $urandom_range(16, 1024);
		endcase
	endfunction

	function automatic int pick_ratio();
		case ($urandom_range(0, 9))
			0, 1:    return $urandom_range(0, 131071);
			2:       return $urandom_range(60000, 65536);
			default: return $urandom_range(0, 60000);
		endcase
	endfunction

	function automatic int pick_dim();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(0, 16383);
		return $urandom_range(1, 8192);
	endfunction

	// Stimulus: directed settings first, then random phases.
	initial begin
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset setting: single tile, tiny image, cut list, odd extremes.
		send_image(640, 640);
		send_image(1, 1);
		send_image(8192, 8192);
		send_image(16383, 0);
		send_image(0, 16383);
		send_image(1280, 720);
		end_phase();

		// Zero tile size and zero limit.
		set_config(0, 0, 0, 0, 0);
		send_image(100, 200);
		send_image(0, 0);
		end_phase();

		// One pixel tiles: saturating count across, full overlap down.
		set_config(1, 1, 65535, 65536, 127);
		send_image(8192, 5);
		send_image(16383, 16383);
		end_phase();

		// Overlap above one and a limit of one tile.
		set_config(4096, 8191, 0, 131071, 1);
		send_image(16383, 16383);
		send_image(5000, 8191);
		end_phase();

		// Large strides whose origins leave the signed field range.
		write_reg(CFG_SPARE, CFG_W'($urandom));
		set_config(4096, 8192, 0, 32768, 64);
		send_image(16383, 100);
		send_image(16383, 16383);

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			end_phase();
			quiet = (p == RANDOM_PHASES - 1);
			set_config(pick_tile(), pick_tile(), pick_ratio(), pick_ratio(),
				$urandom_range(0, 1) ? $urandom_range(0, 127) : MAX_TILES);
			repeat (IMAGES_PER_PHASE)
				send_image(pick_dim(), pick_dim());
		end
		end_phase();
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("Sent %0d image requests under %0d register settings; %0d tiles compared.",
			images_sent, settings_used, tiles_checked);
		$display("%s%s", "Settings reached zero and maximum tile sizes, overlaps of one ",
			"and above, and limits from zero to past the cap.");
		if (tile_errors == 0 && tiles_pending == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
